FILE: design/one_dimensional_kmeans_unit_assert.svh
// Assertion macros used by the checker of the k-means unit.
// Depends on nothing; include with the bare file name.
`ifndef ONE_DIMENSIONAL_KMEANS_UNIT_ASSERT_SVH
`define ONE_DIMENSIONAL_KMEANS_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define KM_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KM_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

FILE: design/kmu_pkg.sv
// Package of the one-dimensional k-means unit: widths, limits, result kinds.
// Used by the top level and the checker; no dependencies.
`timescale 1ns / 1ps
package kmu_pkg;
  localparam int SampleW     = 24;
  localparam int LabelW      = 4;
  localparam int IndexW      = 5;
  localparam int CfgW        = 5;
  localparam int MaxPointsD  = 32;
  localparam int MaxClustD   = 16;
  localparam int MaxPassesD  = 60;
  localparam logic KindCenter = 1'b0;
  localparam logic KindLabel  = 1'b1;
endpackage

FILE: design/kmu_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module kmu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/kmu_divider.sv
// Restoring signed-floor divider: floor(num / den), den > 0, one bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module kmu_divider #(
  parameter int NumW = 32,
  parameter int DenW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [NumW-1:0] quo_o
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] mag_q, mag_d, quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;
  logic [NumW-1:0] qfix;

  always_comb begin
    mag_d = mag_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      neg_d  = num_i[NumW-1];
      // for floor on negatives: floor(-m/d) = -((m + d - 1) / d)
      mag_d  = num_i[NumW-1] ? (NumW'(-num_i) + NumW'(den_i) - NumW'(1))
                             : NumW'(num_i);
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], mag_q[NumW-1]};
      mag_d = {mag_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign qfix   = neg_q ? NumW'(-quo_q) : quo_q;
  assign quo_o  = signed'(qfix);
  assign done_o = done_q;
endmodule

FILE: design/one_dimensional_kmeans_unit.sv
// Top level of the one-dimensional k-means unit (Lloyd iteration).
// Depends on kmu_pkg, kmu_ram and kmu_divider.
`timescale 1ns / 1ps
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | sample_value, last_sample
//  out     | output    | out_valid/out_ready| kind, index, center, label, flags
//  cfg     | input     | cfg_we             | cfg_data (cluster_count)
//
// Load one sample word a cycle. The last sample starts a run: the labels are cleared,
// each start center is picked with an index divide, and each pass sweeps every
// sample over the k centers, then divides each nonempty cluster's sum for its mean.
// Results stream one word a cycle from a single output register; a stalled word
// holds the sequencer, and intake stays off until the last result word is taken.
// Reset clears control state and the cluster sums and counts; every store is written before it is read.
module one_dimensional_kmeans_unit #(
  parameter int MaxPoints   = kmu_pkg::MaxPointsD,
  parameter int MaxClusters = kmu_pkg::MaxClustD,
  parameter int MaxPasses   = kmu_pkg::MaxPassesD
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [kmu_pkg::SampleW-1:0]  sample_value_i,
  input  logic                                last_sample_i,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                result_kind_o,
  output logic [kmu_pkg::IndexW-1:0]          entry_index_o,
  output logic signed [kmu_pkg::SampleW-1:0]  center_value_o,
  output logic [kmu_pkg::LabelW-1:0]          cluster_label_o,
  output logic                                overflow_flag_o,
  output logic                                last_result_o,
  input  logic                                cfg_we,
  input  logic [kmu_pkg::CfgW-1:0]            cfg_data
);
  localparam int SW   = kmu_pkg::SampleW;
  localparam int PA   = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int NW   = $clog2(MaxPoints + 1);
  localparam int CA   = $clog2(MaxClusters);
  localparam int KW   = $clog2(MaxClusters + 1);
  localparam int SumW = SW + NW + 1;
  localparam int PW   = $clog2(MaxPasses + 1);
  localparam int MulW = 2 * (NW + KW + 1);

  typedef enum logic [11:0] {
    StLoad   = 12'b000000000001,
    StInit   = 12'b000000000010,
    StInitRd = 12'b000000000100,
    StRdS    = 12'b000000001000,
    StCmp    = 12'b000000010000,
    StLblWr  = 12'b000000100000,
    StDivSt  = 12'b000001000000,
    StDivWt  = 12'b000010000000,
    StOutC   = 12'b000100000000,
    StOutL   = 12'b001000000000,
    StRdL    = 12'b010000000000,
    StClr    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [kmu_pkg::CfgW-1:0] cfg_q;
  logic [NW-1:0] n_q, n_d, i_q, i_d;
  logic [KW-1:0] k_q, k_d, j_q, j_d;
  logic          drop_q, drop_d, chg_q, chg_d;
  logic [PW-1:0] pass_q, pass_d;
  logic signed [SW-1:0] cur_q, cur_d;
  logic [SW:0]   best_q, best_d;
  logic [CA-1:0] bk_q, bk_d;
  logic signed [SumW-1:0] sum_q [MaxClusters];
  logic [NW-1:0]          cnt_q [MaxClusters];
  logic                   sum_clr, sum_add;
  logic [CA-1:0]          sum_idx;

  // memories
  logic s_we, l_we, c_we;
  logic [PA-1:0] s_wa, s_ra, l_wa, l_ra;
  logic [CA-1:0] c_wa, c_ra;
  logic signed [SW-1:0] s_wd, s_rd, c_wd, c_rd;
  logic [kmu_pkg::LabelW-1:0] l_wd, l_rd;

  kmu_ram #(.Width(SW), .Depth(MaxPoints)) u_samples (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  kmu_ram #(.Width(kmu_pkg::LabelW), .Depth(MaxPoints)) u_labels (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd));
  kmu_ram #(.Width(SW), .Depth(MaxClusters)) u_centers (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));

  // divider for rounded means, floor((2*sum + cnt) / (2*cnt)), and start indices
  localparam int DNW = SumW + 2;
  logic dv_start, dv_done;
  logic signed [DNW-1:0] dv_num, dv_quo;
  logic [NW:0] dv_den;
  kmu_divider #(.NumW(DNW), .DenW(NW + 1)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo));

  // output register
  logic ov_q, ov_d, ok_q, ok_d, ol_q, ol_d, ofl_q, ofl_d;
  logic [kmu_pkg::IndexW-1:0] oi_q, oi_d;
  logic signed [SW-1:0] oc_q, oc_d;
  logic [kmu_pkg::LabelW-1:0] olb_q, olb_d;
  logic out_free;
  assign out_free = !ov_q || out_ready;

  // start index of center j: floor((2(j+1)(n-1) + k+1) / (2(k+1))), clamped to
  // n-1; the quotient comes from the shared divider
  logic [MulW-1:0] ini_num;
  logic [SW:0] dabs;
  logic signed [SW:0] sdiff;
  assign sdiff = {cur_q[SW-1], cur_q} - {c_rd[SW-1], c_rd};
  assign dabs  = sdiff[SW] ? (SW+1)'(-sdiff) : sdiff;

  assign ini_num = MulW'(2) * MulW'(j_q + KW'(1)) * MulW'(n_q - NW'(1))
                 + MulW'(k_q) + MulW'(1);

  logic [CA-1:0] cl_sel;
  logic [NW:0]   cnt_sel;
  logic signed [SumW-1:0] sum_sel;
  assign cl_sel  = j_q[CA-1:0];
  assign cnt_sel = {1'b0, cnt_q[cl_sel]};
  assign sum_sel = sum_q[cl_sel];

  logic init_phase_q, init_phase_d;

  always_comb begin
    state_d = state_q; n_d = n_q; i_d = i_q; k_d = k_q; j_d = j_q;
    drop_d = drop_q; chg_d = chg_q; pass_d = pass_q; cur_d = cur_q;
    best_d = best_q; bk_d = bk_q; init_phase_d = init_phase_q;
    ov_d = ov_q && !out_ready; ok_d = ok_q; oi_d = oi_q; oc_d = oc_q; olb_d = olb_q;
    ofl_d = ofl_q; ol_d = ol_q;
    s_we = 1'b0; s_wa = n_q[PA-1:0]; s_wd = sample_value_i; s_ra = i_q[PA-1:0];
    l_we = 1'b0; l_wa = i_q[PA-1:0]; l_wd = '0; l_ra = i_q[PA-1:0];
    c_we = 1'b0; c_wa = cl_sel; c_wd = '0; c_ra = j_q[CA-1:0];
    sum_clr = 1'b0; sum_add = 1'b0; sum_idx = bk_q;
    dv_start = 1'b0; dv_num = '0; dv_den = '0;
    in_ready = 1'b0;
    unique case (state_q)
      StLoad: begin
        // hold intake while the final word of the previous run still waits
        in_ready = !ov_q;
        if (in_valid && !ov_q) begin
          if (n_q < NW'(MaxPoints)) begin
            s_we = 1'b1;
            n_d  = n_q + NW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_sample_i) begin
            if (cfg_q == '0) k_d = KW'(1);
            else if (cfg_q > kmu_pkg::CfgW'(MaxClusters)) k_d = KW'(MaxClusters);
            else k_d = KW'(cfg_q);
            i_d = '0; j_d = '0; pass_d = '0; chg_d = 1'b0;
            init_phase_d = 1'b1;
            state_d = StClr;
          end
        end
      end
      StClr: begin
        // zero labels, clear sums, then either init centers or go to sweep
        l_we = (i_q < n_q); l_wd = '0;
        sum_clr = 1'b1;
        if (i_q + NW'(1) >= n_q) begin
          i_d = '0; j_d = '0;
          if (k_q == KW'(1)) begin
            // mean of all: accumulate into cluster 0 via one sweep pass
            init_phase_d = 1'b0;
            pass_d = PW'(MaxPasses - 1);
            state_d = StRdS;
          end else state_d = StInit;
        end else i_d = i_q + NW'(1);
      end
      StInit: begin
        // use the divider to compute start index of center j
        dv_start = 1'b1;
        dv_num = DNW'(ini_num);
        dv_den = (NW+1)'(2 * (k_q + KW'(1)));
        state_d = StDivWt;
      end
      StInitRd: begin
        c_we = 1'b1; c_wa = j_q[CA-1:0]; c_wd = s_rd;
        if (j_q + KW'(1) == k_q) begin
          j_d = '0; i_d = '0; init_phase_d = 1'b0; state_d = StRdS;
        end else begin
          j_d = j_q + KW'(1); state_d = StInit;
        end
      end
      StRdS: begin
        // sample i and center 0 arrive next cycle
        s_ra = i_q[PA-1:0]; l_ra = i_q[PA-1:0]; c_ra = '0; j_d = '0;
        state_d = StRdL;
      end
      StRdL: begin
        cur_d = s_rd;
        c_ra = '0; j_d = KW'(1);
        best_d = '1; bk_d = '0;
        state_d = StCmp;
      end
      StCmp: begin
        // center j-1 data on c_rd; strict compare keeps the lower index on a tie
        c_ra = j_q[CA-1:0];
        if (k_q == KW'(1) || dabs < best_q) begin
          best_d = dabs; bk_d = CA'(j_q - KW'(1));
        end
        if (j_q >= k_q) state_d = StLblWr;
        else j_d = j_q + KW'(1);
      end
      StLblWr: begin
        l_we = 1'b1; l_wd = kmu_pkg::LabelW'(bk_q);
        if (l_rd != kmu_pkg::LabelW'(bk_q)) chg_d = 1'b1;
        sum_add = 1'b1; sum_idx = bk_q;
        if (i_q + NW'(1) >= n_q) begin
          j_d = '0; state_d = StDivSt;
        end else begin
          i_d = i_q + NW'(1); state_d = StRdS;
        end
      end
      StDivSt: begin
        if (j_q >= k_q) begin
          if (!chg_q || pass_q + PW'(1) >= PW'(MaxPasses)) begin
            j_d = '0; i_d = '0; state_d = StOutC; c_ra = '0;
          end else begin
            pass_d = pass_q + PW'(1); chg_d = 1'b0; i_d = '0;
            sum_clr = 1'b1; state_d = StRdS;
          end
        end else if (cnt_sel == '0) begin
          // empty cluster keeps its center
          j_d = j_q + KW'(1);
        end else begin
          dv_start = 1'b1;
          dv_num = DNW'(2) * DNW'(sum_sel) + DNW'(cnt_sel);
          dv_den = (NW+1)'(cnt_sel << 1);
          state_d = StDivWt;
        end
      end
      StDivWt: begin
        if (dv_done) begin
          if (init_phase_q) begin
            s_ra = (dv_quo > DNW'(n_q - NW'(1))) ? PA'(n_q - NW'(1)) : PA'(dv_quo);
            state_d = StInitRd;
          end else begin
            c_we = 1'b1; c_wa = j_q[CA-1:0]; c_wd = SW'(dv_quo);
            j_d = j_q + KW'(1); state_d = StDivSt;
          end
        end
      end
      StOutC: begin
        // center j data valid on c_rd (read issued last cycle)
        c_ra = j_q[CA-1:0];
        if (out_free) begin
          ov_d = 1'b1; ok_d = kmu_pkg::KindCenter; oi_d = kmu_pkg::IndexW'(j_q);
          oc_d = c_rd; olb_d = '0; ofl_d = drop_q;
          ol_d = (n_q == '0) && (j_q + KW'(1) == k_q);
          if (j_q + KW'(1) == k_q) begin
            i_d = '0; l_ra = '0;
            state_d = (n_q == '0) ? StLoad : StOutL;
            if (n_q == '0) begin n_d = '0; drop_d = 1'b0; end
          end else begin
            // advance the read address with the index
            j_d = j_q + KW'(1); c_ra = CA'(j_q + KW'(1));
            state_d = StOutC;
          end
        end
      end
      StOutL: begin
        l_ra = i_q[PA-1:0];
        if (out_free) begin
          ov_d = 1'b1; ok_d = kmu_pkg::KindLabel; oi_d = kmu_pkg::IndexW'(i_q);
          oc_d = '0; olb_d = l_rd; ofl_d = drop_q;
          ol_d = (i_q + NW'(1) == n_q);
          if (i_q + NW'(1) == n_q) begin
            n_d = '0; drop_d = 1'b0; state_d = StLoad;
          end else begin
            i_d = i_q + NW'(1); l_ra = PA'(i_q + NW'(1));
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; cfg_q <= kmu_pkg::CfgW'(2);
      n_q <= '0; i_q <= '0; k_q <= '0; j_q <= '0; drop_q <= 1'b0; chg_q <= 1'b0;
      pass_q <= '0; ov_q <= 1'b0; init_phase_q <= 1'b0;
    end else begin
      if (cfg_we) cfg_q <= cfg_data;
      state_q <= state_d; n_q <= n_d; i_q <= i_d; j_q <= j_d;
      drop_q <= drop_d; ov_q <= ov_d;
      k_q <= k_d; chg_q <= chg_d; pass_q <= pass_d; init_phase_q <= init_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; best_q <= best_d; bk_q <= bk_d;
    ok_q <= ok_d; oi_q <= oi_d; oc_q <= oc_d; olb_q <= olb_d; ofl_q <= ofl_d;
    ol_q <= ol_d;
  end

  // cluster sums and counts: cleared on a new pass, accumulated per sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MaxClusters; c++) begin
        sum_q[c] <= '0; cnt_q[c] <= '0;
      end
    end else if (sum_clr) begin
      for (int c = 0; c < MaxClusters; c++) begin
        sum_q[c] <= '0; cnt_q[c] <= '0;
      end
    end else if (sum_add) begin
      sum_q[sum_idx] <= sum_q[sum_idx] + SumW'(cur_q);
      cnt_q[sum_idx] <= cnt_q[sum_idx] + NW'(1);
    end
  end

  assign out_valid       = ov_q;
  assign result_kind_o   = ok_q;
  assign entry_index_o   = oi_q;
  assign center_value_o  = oc_q;
  assign cluster_label_o = olb_q;
  assign overflow_flag_o = ofl_q;
  assign last_result_o   = ol_q;
endmodule

FILE: design/kmu_checker.sv
// Port-level checker for the k-means unit, bound to the top level.
// Depends on kmu_pkg and one_dimensional_kmeans_unit_assert.svh.
`timescale 1ns / 1ps
`include "one_dimensional_kmeans_unit_assert.svh"
module kmu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              result_kind_o,
  input logic [kmu_pkg::LabelW-1:0]        cluster_label_o,
  input logic signed [kmu_pkg::SampleW-1:0] center_value_o,
  input logic                              last_result_o
);
  // no new samples while results are pending
  `KM_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, out_valid, !in_ready)
  // label words carry a zero center
  `KM_ASSERT_IMP(a_label_zero_center, clk_i, rst_ni,
                 out_valid && result_kind_o == kmu_pkg::KindLabel, center_value_o == '0)
  // center words carry a zero label
  `KM_ASSERT_IMP(a_center_zero_label, clk_i, rst_ni,
                 out_valid && result_kind_o == kmu_pkg::KindCenter, cluster_label_o == '0)
  // a stalled word holds
  `KM_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
endmodule

bind one_dimensional_kmeans_unit kmu_checker u_kmu_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready, .result_kind_o,
  .cluster_label_o, .center_value_o, .last_result_o);
